### hdl/mouse_packet_cursor_tracker_assert.svh
// Assertion macros used by the mouse packet cursor tracker checker.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define MPCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpct assertion failed");

// Next-cycle implication, disabled while rst is high.
`define MPCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpct assertion failed");

`endif

### hdl/mpct_pkg.sv
// Types and constants of the mouse packet cursor tracker.
package mpct_pkg;

   localparam int COORD_W    = 12;
   localparam int DATA_W     = 8;
   localparam int BTN_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   typedef logic [DATA_W-1:0]     data_byte_type;
   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [BTN_W-1:0]      buttons_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_ENABLE  = 2'd0;
   localparam csr_index_type CSR_X_LIMIT = 2'd1;
   localparam csr_index_type CSR_Y_LIMIT = 2'd2;

   // Header byte layout.
   localparam int SYNC_BIT   = 3;
   localparam int X_SIGN_BIT = 4;
   localparam int Y_SIGN_BIT = 5;

   // Reset values.
   localparam coord_type POS_X_RESET   = 12'd512;
   localparam coord_type POS_Y_RESET   = 12'd384;
   localparam coord_type X_LIMIT_RESET = 12'd1024;
   localparam coord_type Y_LIMIT_RESET = 12'd768;

endpackage

### hdl/mpct_if.sv
// Handshake interfaces for the request, response and register-write channels.
interface mpct_req_if;
   logic                    valid;
   logic                    ready;
   mpct_pkg::data_byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mpct_rsp_if;
   logic                  valid;
   logic                  ready;
   mpct_pkg::coord_type   cursor_x;
   mpct_pkg::coord_type   cursor_y;
   mpct_pkg::buttons_type buttons;
   logic                  changed;

   modport source (output valid, output cursor_x, output cursor_y, output buttons,
                   output changed, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input buttons,
                   input changed, output ready);
endinterface

interface mpct_csr_if;
   logic                    valid;
   logic                    ready;
   mpct_pkg::csr_index_type index;
   mpct_pkg::csr_data_type  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hdl/mouse_packet_cursor_tracker.sv
// Mouse packet cursor tracker: assembles three-byte mouse packets into cursor reports.
//
// Usage: every request on req_bus carries one byte received from the mouse. Three bytes
// (header, X delta, Y delta) form a packet; while a header is expected, a byte whose sync
// bit (bit 3) is clear is consumed and dropped so framing can recover. When the Y delta
// byte is taken, the signed deltas move the cursor (X added, Y subtracted), each
// coordinate is clamped to 0..limit, and one response appears on rsp_bus in the next
// cycle with the position, the buttons and a flag telling whether anything differs from
// the last response. The very first response is always flagged. Registers are written
// through csr_bus (enable, x_limit, y_limit); the user must write them only while the
// block is idle, which the block does not enforce. csr_bus is always ready. While enable
// is clear, requests are still accepted but ignored. Throughput: one byte per cycle, set
// by the single result register in front of rsp_bus, unless the receiver stalls with a
// response pending: req_bus.ready then drops until it is taken, so nothing is lost.
// Synchronous reset returns to awaiting a header, puts the cursor at (512, 384), the
// limits at (1024, 768), clears enable and forgets the last report.
module mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   mpct_req_if.sink    req_bus,
   mpct_rsp_if.source  rsp_bus,
   mpct_csr_if.sink    csr_bus
);

   // Positions never exceed the 12-bit limit registers, nor 2^COORD_BITS - 1.
   localparam int POS_W = (COORD_BITS < mpct_pkg::COORD_W) ? COORD_BITS : mpct_pkg::COORD_W;
   // Two extra bits hold the sign and the overshoot of position plus a 9-bit delta.
   localparam int SUM_W = POS_W + 2;
   localparam int EXT_W = SUM_W - mpct_pkg::DATA_W - 1;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Packet phase codes.
   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_XDELTA = 2'd1;
   localparam logic [1:0] PHASE_YDELTA = 2'd2;

   // Configuration registers.
   logic                enable_ff, enable_in;
   mpct_pkg::coord_type x_limit_ff, x_limit_in;
   mpct_pkg::coord_type y_limit_ff, y_limit_in;

   // Packet assembly and cursor state.
   logic [1:0]              phase_ff, phase_in;
   mpct_pkg::data_byte_type header_ff, header_in;
   mpct_pkg::data_byte_type xdelta_ff, xdelta_in;
   logic [POS_W-1:0]        pos_x_ff, pos_x_in;
   logic [POS_W-1:0]        pos_y_ff, pos_y_in;
   logic [POS_W-1:0]        last_x_ff, last_x_in;
   logic [POS_W-1:0]        last_y_ff, last_y_in;
   mpct_pkg::buttons_type   last_btn_ff, last_btn_in;
   logic                    reported_ff, reported_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]      rsp_y_ff, rsp_y_in;
   mpct_pkg::buttons_type rsp_btn_ff, rsp_btn_in;
   logic                  rsp_changed_ff, rsp_changed_in;

   logic                    req_fire;
   logic                    finish;
   mpct_pkg::data_byte_type rx_byte;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;
   logic [POS_W-1:0]        top_x;
   logic [POS_W-1:0]        top_y;
   logic [POS_W-1:0]        new_x;
   logic [POS_W-1:0]        new_y;
   mpct_pkg::buttons_type   new_btn;
   logic                    new_changed;

   // Clamp a signed sum to 0..top.
   function automatic logic [POS_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                    input logic [POS_W-1:0] top);
      logic [POS_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({2'b00, top})) begin
         res = top;
      end else begin
         res = v[POS_W-1:0];
      end
      return res;
   endfunction

   // A limit wider than the coordinate range saturates to the largest coordinate.
   function automatic logic [POS_W-1:0] sat_limit(input mpct_pkg::coord_type lim);
      logic [POS_W-1:0] res;
      if (lim > mpct_pkg::COORD_W'(POS_MAX)) begin
         res = POS_MAX;
      end else begin
         res = lim[POS_W-1:0];
      end
      return res;
   endfunction

   // A new byte may enter whenever the response register is empty or being drained.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rx_byte       = req_bus.data_byte;
   assign csr_bus.ready = 1'b1;

   // Cursor arithmetic for the packet that completes with rx_byte as its Y delta.
   assign top_x = sat_limit(x_limit_ff);
   assign top_y = sat_limit(y_limit_ff);
   assign sum_x = $signed({2'b00, pos_x_ff})
                + $signed({{EXT_W{header_ff[mpct_pkg::X_SIGN_BIT]}},
                           header_ff[mpct_pkg::X_SIGN_BIT], xdelta_ff});
   assign sum_y = $signed({2'b00, pos_y_ff})
                - $signed({{EXT_W{header_ff[mpct_pkg::Y_SIGN_BIT]}},
                           header_ff[mpct_pkg::Y_SIGN_BIT], rx_byte});
   assign new_x       = clamp_coord(sum_x, top_x);
   assign new_y       = clamp_coord(sum_y, top_y);
   assign new_btn     = header_ff[mpct_pkg::BTN_W-1:0];
   assign new_changed = !reported_ff || (new_x != last_x_ff) || (new_y != last_y_ff)
                      || (new_btn != last_btn_ff);

   // Register writes.
   always_comb begin
      enable_in  = enable_ff;
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            mpct_pkg::CSR_ENABLE:  enable_in  = csr_bus.wdata[0];
            mpct_pkg::CSR_X_LIMIT: x_limit_in = csr_bus.wdata;
            mpct_pkg::CSR_Y_LIMIT: y_limit_in = csr_bus.wdata;
            default: begin
            end
         endcase
      end
   end

   // Packet assembly: bytes are consumed only while enabled.
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      xdelta_in = xdelta_ff;
      finish    = 1'b0;
      if (req_fire && enable_ff) begin
         unique case (phase_ff)
            PHASE_HEADER: begin
               if (rx_byte[mpct_pkg::SYNC_BIT]) begin
                  header_in = rx_byte;
                  phase_in  = PHASE_XDELTA;
               end
            end
            PHASE_XDELTA: begin
               xdelta_in = rx_byte;
               phase_in  = PHASE_YDELTA;
            end
            default: begin
               // Y delta byte; the unused fourth code behaves the same way.
               phase_in = PHASE_HEADER;
               finish   = 1'b1;
            end
         endcase
      end
   end

   // Cursor, last report and response register.
   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      last_btn_in    = last_btn_ff;
      reported_in    = reported_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_btn_in     = rsp_btn_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      if (finish) begin
         pos_x_in       = new_x;
         pos_y_in       = new_y;
         last_x_in      = new_x;
         last_y_in      = new_y;
         last_btn_in    = new_btn;
         reported_in    = 1'b1;
         rsp_x_in       = new_x;
         rsp_y_in       = new_y;
         rsp_btn_in     = new_btn;
         rsp_changed_in = new_changed;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         x_limit_ff   <= mpct_pkg::X_LIMIT_RESET;
         y_limit_ff   <= mpct_pkg::Y_LIMIT_RESET;
         phase_ff     <= PHASE_HEADER;
         header_ff    <= '0;
         xdelta_ff    <= '0;
         pos_x_ff     <= mpct_pkg::POS_X_RESET[POS_W-1:0];
         pos_y_ff     <= mpct_pkg::POS_Y_RESET[POS_W-1:0];
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_btn_ff  <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         x_limit_ff   <= x_limit_in;
         y_limit_ff   <= y_limit_in;
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         xdelta_ff    <= xdelta_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         last_btn_ff  <= last_btn_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_btn_ff     <= rsp_btn_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.cursor_x = mpct_pkg::COORD_W'(rsp_x_ff);
   assign rsp_bus.cursor_y = mpct_pkg::COORD_W'(rsp_y_ff);
   assign rsp_bus.buttons  = rsp_btn_ff;
   assign rsp_bus.changed  = rsp_changed_ff;

endmodule

### hdl/mpct_checker.sv
// Port-level checker for the mouse packet cursor tracker, bound to the top level.
`include "mouse_packet_cursor_tracker_assert.svh"

module mpct_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A pending response is held until taken.
   `MPCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Nothing is reported right after reset.
   `MPCT_ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_valid)

   // Every new response comes from a byte accepted in the cycle before.
   `MPCT_ASSERT_NOW(a_rsp_from_req, clock, reset,
                    rsp_valid && (!$past(rsp_valid) || $past(rsp_ready)),
                    $past(req_valid && req_ready))

   // With no response pending, a byte is always taken.
   `MPCT_ASSERT_NOW(a_req_ready_when_empty, clock, reset, !rsp_valid, req_ready)

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);

### tb/mouse_packet_cursor_tracker_tb.sv
// Self-checking testbench for the mouse packet cursor tracker, with its scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
   mpct_pkg::coord_type   x;
   mpct_pkg::coord_type   y;
   mpct_pkg::buttons_type btn;
   logic                  chg;
} cursor_report_type;

// Tracks the packet framing and the cursor on its own and checks each report.
class cursor_scoreboard;
   logic                    enabled;
   mpct_pkg::coord_type     x_lim;
   mpct_pkg::coord_type     y_lim;
   logic [1:0]              phase;
   mpct_pkg::data_byte_type header;
   mpct_pkg::data_byte_type x_byte;
   mpct_pkg::coord_type     cur_x;
   mpct_pkg::coord_type     cur_y;
   mpct_pkg::coord_type     prev_x;
   mpct_pkg::coord_type     prev_y;
   mpct_pkg::buttons_type   prev_btn;
   bit                      seen_report;
   cursor_report_type       expected_q[$];
   int                      mismatches;
   int                      requests_seen;
   int                      reports_checked;
   int                      flagged_reports;
   int                      csr_writes;

   function new();
      enabled         = 1'b0;
      x_lim           = mpct_pkg::X_LIMIT_RESET;
      y_lim           = mpct_pkg::Y_LIMIT_RESET;
      phase           = 2'd0;
      header          = '0;
      x_byte          = '0;
      cur_x           = mpct_pkg::POS_X_RESET;
      cur_y           = mpct_pkg::POS_Y_RESET;
      prev_x          = '0;
      prev_y          = '0;
      prev_btn        = '0;
      seen_report     = 1'b0;
      mismatches      = 0;
      requests_seen   = 0;
      reports_checked = 0;
      flagged_reports = 0;
      csr_writes      = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   function void write_register(mpct_pkg::csr_index_type idx, mpct_pkg::csr_data_type val);
      csr_writes++;
      case (idx)
         mpct_pkg::CSR_ENABLE:  enabled = val[0];
         mpct_pkg::CSR_X_LIMIT: x_lim = val;
         mpct_pkg::CSR_Y_LIMIT: y_lim = val;
         default: ;
      endcase
   endfunction

   function int clamp_to_limit(int v, mpct_pkg::coord_type lim);
      int top;
      top = int'(lim);
      if (top > (1 << mpct_pkg::COORD_W) - 1)
         top = (1 << mpct_pkg::COORD_W) - 1;
      if (v < 0)
         return 0;
      if (v > top)
         return top;
      return v;
   endfunction

   function void note_request(mpct_pkg::data_byte_type b);
      int                dx;
      int                dy;
      cursor_report_type r;
      requests_seen++;
      if (!enabled)
         return;
      if (phase == 2'd0) begin
         // Framing is regained by skipping bytes that cannot be a header.
         if (b[mpct_pkg::SYNC_BIT]) begin
            header = b;
            phase  = 2'd1;
         end
         return;
      end
      if (phase == 2'd1) begin
         x_byte = b;
         phase  = 2'd2;
         return;
      end
      phase = 2'd0;
      dx = int'(x_byte);
      if (header[mpct_pkg::X_SIGN_BIT])
         dx -= 256;
      dy = int'(b);
      if (header[mpct_pkg::Y_SIGN_BIT])
         dy -= 256;
      cur_x = mpct_pkg::coord_type'(clamp_to_limit(int'(cur_x) + dx, x_lim));
      cur_y = mpct_pkg::coord_type'(clamp_to_limit(int'(cur_y) - dy, y_lim));
      r.x   = cur_x;
      r.y   = cur_y;
      r.btn = header[mpct_pkg::BTN_W-1:0];
      r.chg = !seen_report || cur_x != prev_x || cur_y != prev_y || r.btn != prev_btn;
      seen_report = 1'b1;
      prev_x      = cur_x;
      prev_y      = cur_y;
      prev_btn    = r.btn;
      expected_q.push_back(r);
   endfunction

   task check_response(cursor_report_type got);
      cursor_report_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected report x=%0d y=%0d buttons=%0d changed=%0d",
                          got.x, got.y, got.btn, got.chg));
      end else begin
         want = expected_q.pop_front();
         reports_checked++;
         if (got.chg === 1'b1)
            flagged_reports++;
         if (got.x !== want.x)
            report($sformatf("report %0d: cursor_x %0d, expected %0d",
                             reports_checked, got.x, want.x));
         if (got.y !== want.y)
            report($sformatf("report %0d: cursor_y %0d, expected %0d",
                             reports_checked, got.y, want.y));
         if (got.btn !== want.btn)
            report($sformatf("report %0d: buttons %0d, expected %0d",
                             reports_checked, got.btn, want.btn));
         if (got.chg !== want.chg)
            report($sformatf("report %0d: changed %0d, expected %0d",
                             reports_checked, got.chg, want.chg));
      end
   endtask
endclass

module mouse_packet_cursor_tracker_tb;

   localparam int CLOCK_PERIOD  = 12;
   // The report is registered straight from the third byte, so SETTLE_CYCLES quiet
   // cycles are plenty for any byte still in flight to settle.
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 3000;
   localparam int DRAIN_LIMIT   = 1000;
   localparam int PHASE_BYTES   = 210;
   localparam int PHASE_COUNT   = 9;

   // Opening sequence, sent with the block enabled at its reset limits. It
   // starts with two bytes whose sync bit is clear, which must be dropped,
   // then a still packet that gives the first report (always flagged), the
   // same packet again (not flagged), and packets that exercise both sign
   // bits, the extreme delta values and a header with every bit set.
   localparam mpct_pkg::data_byte_type OPENING [0:22] = '{
      8'h00, 8'hF7,
      8'h08, 8'h00, 8'h00,
      8'h08, 8'h00, 8'h00,
      8'h1F, 8'h00, 8'h80,
      8'h3D, 8'hFF, 8'hFF,
      8'h08, 8'hFF, 8'h00,
      8'hFF, 8'h01, 8'h01,
      8'h38, 8'h00, 8'h00
   };

   logic clock;
   logic reset;

   mpct_req_if req_bus ();
   mpct_rsp_if rsp_bus ();
   mpct_csr_if csr_bus ();

   cursor_scoreboard board;

   // Percent chance per cycle that the sender holds back or the receiver stalls.
   int                    send_idle_pct;
   int                    recv_idle_pct;
   mpct_pkg::buttons_type last_buttons_sent;

   mouse_packet_cursor_tracker DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Sends one byte as a request. The sender may idle first; valid is only
   // lowered in a cycle of its own, so it never drops and rises in one step.
   task automatic send_byte(input mpct_pkg::data_byte_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= mpct_pkg::data_byte_type'($urandom_range(255));
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do
         @(posedge clock);
      while (!req_bus.ready);
      board.note_request(b);
   endtask

   // A well-formed packet with random content. Some packets carry no motion
   // and repeat the previous buttons, so that unflagged reports show up too.
   task automatic send_packet();
      mpct_pkg::data_byte_type head;
      head                     = mpct_pkg::data_byte_type'($urandom_range(255));
      head[mpct_pkg::SYNC_BIT] = 1'b1;
      if ($urandom_range(99) < 15) begin
         head[mpct_pkg::BTN_W-1:0]  = last_buttons_sent;
         head[mpct_pkg::X_SIGN_BIT] = 1'b0;
         head[mpct_pkg::Y_SIGN_BIT] = 1'b0;
         send_byte(head);
         send_byte(8'h00);
         send_byte(8'h00);
      end else begin
         send_byte(head);
         send_byte(mpct_pkg::data_byte_type'($urandom_range(255)));
         send_byte(mpct_pkg::data_byte_type'($urandom_range(255)));
      end
      last_buttons_sent = head[mpct_pkg::BTN_W-1:0];
   endtask

   task automatic write_csr(input mpct_pkg::csr_index_type idx,
                            input mpct_pkg::csr_data_type val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      board.write_register(idx, val);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Only bit 0 of the enable register counts; the upper bits are random
   // to make sure the block ignores them.
   task automatic set_enable(input bit en);
      mpct_pkg::csr_data_type w;
      w    = mpct_pkg::csr_data_type'($urandom_range(4095));
      w[0] = en;
      write_csr(mpct_pkg::CSR_ENABLE, w);
   endtask

   // Holds the sender back until every expected report has been taken and
   // the block has had time to finish with any byte that gives no report.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The receiver checks each accepted report and then decides at random
   // whether to stall in the next cycle.
   initial begin : receiver
      cursor_report_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.x   = rsp_bus.cursor_x;
            got.y   = rsp_bus.cursor_y;
            got.btn = rsp_bus.buttons;
            got.chg = rsp_bus.changed;
            board.check_response(got);
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // The run is abandoned when no channel has moved anything for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      mpct_pkg::coord_type xl;
      mpct_pkg::coord_type yl;
      int                  sent;
      int                  waited;
      board             = new();
      send_idle_pct     = 35;
      recv_idle_pct     = 48;
      last_buttons_sent = '0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= mpct_pkg::CSR_ENABLE;
      csr_bus.wdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The block comes out of reset disabled, so this byte must be ignored.
      send_byte(8'hFF);
      settle();
      set_enable(1'b1);
      foreach (OPENING[i])
         send_byte(OPENING[i]);

      // Random phases. Each phase writes fresh limits while the block is
      // idle, so the cursor left over from the previous phase is clamped
      // only by the next packet. The pacing runs receiver-heavy idling first,
      // then sender-heavy, and then none at all.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 48;
            end
            1: begin
               send_idle_pct = 48;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         settle();
         if (p == 4) begin
            // A disabled stretch: every byte is taken and thrown away, and a
            // packet that was half assembled stays where it was.
            set_enable(1'b0);
            repeat (16) send_byte(mpct_pkg::data_byte_type'($urandom_range(255)));
            settle();
         end
         case (p)
            0: begin
               xl = 12'd4095;
               yl = 12'd4095;
            end
            1: begin
               // A limit of zero pins the coordinate at zero.
               xl = 12'd0;
               yl = 12'd0;
            end
            2: begin
               xl = 12'd1;
               yl = 12'd1;
            end
            3: begin
               xl = 12'd100;
               yl = 12'd50;
            end
            5: begin
               xl = 12'd4095;
               yl = 12'd1;
            end
            6: begin
               xl = mpct_pkg::X_LIMIT_RESET;
               yl = mpct_pkg::Y_LIMIT_RESET;
            end
            default: begin
               xl = mpct_pkg::coord_type'($urandom_range(4095, 1));
               yl = mpct_pkg::coord_type'($urandom_range(4095, 1));
            end
         endcase
         write_csr(mpct_pkg::CSR_X_LIMIT, xl);
         write_csr(mpct_pkg::CSR_Y_LIMIT, yl);
         set_enable(1'b1);
         // Mostly whole packets; the rest are stray bytes that break framing
         // and force the block to find the next header again.
         sent = 0;
         while (sent < PHASE_BYTES) begin
            if ($urandom_range(9) == 0) begin
               send_byte(mpct_pkg::data_byte_type'($urandom_range(255)));
               sent++;
            end else begin
               send_packet();
               sent += 3;
            end
         end
      end

      req_bus.valid <= 1'b0;
      for (waited = 0; waited < DRAIN_LIMIT && board.pending() > 0; waited++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() > 0)
         board.report($sformatf("%0d expected reports never arrived", board.pending()));

      $display("Run covered %0d requests, %0d reports checked (%0d flagged as changed)",
               board.requests_seen, board.reports_checked, board.flagged_reports);
      $display("with %0d register writes, limits from 0 to 4095 and three pacing modes.",
               board.csr_writes);
      if (board.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### mouse_packet_cursor_tracker.f
+incdir+hdl
hdl/mpct_pkg.sv
hdl/mpct_if.sv
hdl/mouse_packet_cursor_tracker.sv
hdl/mpct_checker.sv
tb/mouse_packet_cursor_tracker_tb.sv
